// ----- hdl/sfd_pkg.sv -----
// Shared types, codes and the CRC-16/XMODEM byte update for the serial frame deframer.
// No dependencies; used by sfd_parser and the top level in hdl/.
package sfd_pkg;

    // escape and frame constants
    localparam logic [7:0]  ESC_BYTE   = 8'h7D;
    localparam logic [7:0]  ESC_FLAG   = 8'h5E;
    localparam logic [7:0]  ESC_ESC    = 8'h5D;
    localparam logic [7:0]  FLAG_BYTE  = 8'h7E;
    localparam logic [7:0]  PKT_TYPE   = 8'h42;
    localparam logic [15:0] CRC_POLY   = 16'h1021;

    localparam int STORE_DEPTH = 32;
    localparam int IDX_W       = 5;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CHECK_CRC   = 1'b0,
        CFG_STRING_TYPE = 1'b1
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_BAD_TYPE   = 3'd1,
        ST_CRC        = 3'd2,
        ST_TOO_LONG   = 3'd3,
        ST_NOT_STRING = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        PH_TYPE    = 3'd0,
        PH_DEST_LO = 3'd1,
        PH_DEST_HI = 3'd2,
        PH_MSG     = 3'd3,
        PH_GROUP   = 3'd4,
        PH_LEN     = 3'd5,
        PH_BODY    = 3'd6
    } t_phase;

    typedef enum logic [2:0] {
        SQ_IDLE   = 3'd0,
        SQ_FEED1  = 3'd1,
        SQ_CLEAR  = 3'd2,
        SQ_FEED2  = 3'd3,
        SQ_ONE    = 3'd4,
        SQ_RUN_RD = 3'd5,
        SQ_RUN_WR = 3'd6
    } t_seq;

    typedef enum logic [1:0] {
        RQ_NONE   = 2'd0,
        RQ_SINGLE = 2'd1,
        RQ_RUN    = 2'd2
    } t_req_kind;

    typedef struct packed {
        logic [7:0] raw_byte;
        logic       buffer_start;
    } t_in_item;

    typedef struct packed {
        logic [15:0]      dest_address;
        logic [7:0]       message_type;
        logic [7:0]       group_id;
        logic [7:0]       payload_length;
        logic [7:0]       payload_byte;
        logic [IDX_W-1:0] byte_index;
        logic             has_payload;
        logic [2:0]       status;
        logic             last;
    } t_out_item;

    typedef struct packed {
        logic [15:0] dest;
        logic [7:0]  msg_code;
        logic [7:0]  group;
        logic [7:0]  length;
    } t_hdr;

    // sequencer -> parser
    typedef struct packed {
        logic       feed;
        logic [7:0] fbyte;
        logic       clear;
        logic       esc_clr;
        logic       esc_set;
    } t_feed_ctl;

    // parser -> sequencer, valid in the cycle of the feed
    typedef struct packed {
        t_req_kind  kind;
        logic [2:0] status;
    } t_feed_rsp;

    typedef struct packed {
        logic esc;
        logic discard;
    } t_parse_flags;

    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] data);
        logic [15:0] c;
        c = crc ^ {data, 8'h00};
        for (int i = 0; i < 8; i++) begin
            c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

// ----- hdl/sfd_payload_ram.sv -----
// Payload store: one write port, one read port with registered read data.
// Standalone; depth and address width come from the top level.
module sfd_payload_ram #(
    parameter int DEPTH  = 32,
    parameter int ADDR_W = 5
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [7:0]        i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [7:0]        o_rdata
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hdl/sfd_parser.sv -----
// Frame parser: header/CRC/escape/discard state and one unescaped byte per feed.
// Depends on sfd_pkg; drives the payload store write port.
module sfd_parser #(
    parameter int CAPACITY = 32,
    parameter int ADDR_W   = 5
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  sfd_pkg::t_feed_ctl   i_ctl,
    input  logic                 i_check_crc,
    input  logic [7:0]           i_string_type,
    output sfd_pkg::t_hdr        o_hdr,
    output sfd_pkg::t_feed_rsp   o_rsp,
    output sfd_pkg::t_parse_flags o_flags,
    output logic                 o_wr_en,
    output logic [ADDR_W-1:0]    o_wr_addr,
    output logic [7:0]           o_wr_data
);

    // count runs to length + 1 (CRC low byte seen)
    localparam int CW = $clog2(CAPACITY + 2);

    sfd_pkg::t_phase r_phase, n_phase;
    logic            r_esc, n_esc;
    logic            r_discard, n_discard;
    sfd_pkg::t_hdr   r_hdr, n_hdr;
    logic [CW-1:0]   r_count, n_count;
    logic [15:0]     r_crc, n_crc;
    logic [7:0]      r_crc_lo, n_crc_lo;

    logic [15:0] crc_in;
    logic [15:0] crc_nx;
    logic [15:0] rx_crc;
    logic [7:0]  count8;

    assign crc_in = (r_phase == sfd_pkg::PH_TYPE) ? 16'h0000 : r_crc;
    assign crc_nx = sfd_pkg::crc16_byte(crc_in, i_ctl.fbyte);
    assign rx_crc = {i_ctl.fbyte, r_crc_lo};
    assign count8 = 8'(r_count);

    always_comb begin
        n_phase   = r_phase;
        n_esc     = r_esc;
        n_discard = r_discard;
        n_hdr     = r_hdr;
        n_count   = r_count;
        n_crc     = r_crc;
        n_crc_lo  = r_crc_lo;
        o_rsp     = '{kind: sfd_pkg::RQ_NONE, status: sfd_pkg::ST_OK};
        o_wr_en   = 1'b0;
        if (i_ctl.clear) begin
            n_phase   = sfd_pkg::PH_TYPE;
            n_esc     = 1'b0;
            n_discard = 1'b0;
            n_hdr     = '0;
            n_count   = '0;
            n_crc     = '0;
            n_crc_lo  = '0;
        end else begin
            if (i_ctl.esc_clr) begin
                n_esc = 1'b0;
            end
            if (i_ctl.esc_set) begin
                n_esc = 1'b1;
            end
            if (i_ctl.feed && !r_discard) begin
                case (r_phase)
                    sfd_pkg::PH_TYPE: begin
                        n_hdr          = '0;
                        n_hdr.msg_code = i_ctl.fbyte;
                        n_count        = '0;
                        n_crc_lo       = '0;
                        n_crc          = crc_nx;
                        n_phase        = sfd_pkg::PH_DEST_LO;
                    end
                    sfd_pkg::PH_DEST_LO: begin
                        // type byte is judged only once the next byte shows up
                        if (r_hdr.msg_code != sfd_pkg::PKT_TYPE) begin
                            n_hdr.msg_code = 8'h00;
                            o_rsp          = '{kind: sfd_pkg::RQ_SINGLE,
                                               status: sfd_pkg::ST_BAD_TYPE};
                            n_discard      = 1'b1;
                            n_phase        = sfd_pkg::PH_TYPE;
                        end else begin
                            n_hdr.dest = {8'h00, i_ctl.fbyte};
                            n_crc      = crc_nx;
                            n_phase    = sfd_pkg::PH_DEST_HI;
                        end
                    end
                    sfd_pkg::PH_DEST_HI: begin
                        n_hdr.dest[15:8] = i_ctl.fbyte;
                        n_crc            = crc_nx;
                        n_phase          = sfd_pkg::PH_MSG;
                    end
                    sfd_pkg::PH_MSG: begin
                        n_hdr.msg_code = i_ctl.fbyte;
                        n_crc          = crc_nx;
                        n_phase        = sfd_pkg::PH_GROUP;
                    end
                    sfd_pkg::PH_GROUP: begin
                        n_hdr.group = i_ctl.fbyte;
                        n_crc       = crc_nx;
                        n_phase     = sfd_pkg::PH_LEN;
                    end
                    sfd_pkg::PH_LEN: begin
                        n_hdr.length = i_ctl.fbyte;
                        if (i_ctl.fbyte > 8'(CAPACITY)) begin
                            o_rsp     = '{kind: sfd_pkg::RQ_SINGLE,
                                          status: sfd_pkg::ST_TOO_LONG};
                            n_discard = 1'b1;
                            n_phase   = sfd_pkg::PH_TYPE;
                        end else begin
                            n_crc   = crc_nx;
                            n_count = '0;
                            n_phase = sfd_pkg::PH_BODY;
                        end
                    end
                    sfd_pkg::PH_BODY: begin
                        if (count8 < r_hdr.length) begin
                            o_wr_en = 1'b1;
                            n_crc   = crc_nx;
                            n_count = r_count + CW'(1);
                        end else if (count8 == r_hdr.length) begin
                            n_crc_lo = i_ctl.fbyte;
                            n_count  = r_count + CW'(1);
                        end else begin
                            n_phase = sfd_pkg::PH_TYPE;
                            if (i_check_crc && (rx_crc != r_crc)) begin
                                o_rsp     = '{kind: sfd_pkg::RQ_SINGLE,
                                              status: sfd_pkg::ST_CRC};
                                n_discard = 1'b1;
                            end else if (r_hdr.msg_code != i_string_type) begin
                                o_rsp = '{kind: sfd_pkg::RQ_SINGLE,
                                          status: sfd_pkg::ST_NOT_STRING};
                            end else if (r_hdr.length == 8'h00) begin
                                o_rsp = '{kind: sfd_pkg::RQ_SINGLE,
                                          status: sfd_pkg::ST_OK};
                            end else begin
                                o_rsp = '{kind: sfd_pkg::RQ_RUN,
                                          status: sfd_pkg::ST_OK};
                            end
                        end
                    end
                    default: begin
                        n_phase = sfd_pkg::PH_TYPE;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= sfd_pkg::PH_TYPE;
            r_esc     <= 1'b0;
            r_discard <= 1'b0;
            r_hdr     <= '0;
            r_count   <= '0;
            r_crc     <= '0;
            r_crc_lo  <= '0;
        end else begin
            r_phase   <= n_phase;
            r_esc     <= n_esc;
            r_discard <= n_discard;
            r_hdr     <= n_hdr;
            r_count   <= n_count;
            r_crc     <= n_crc;
            r_crc_lo  <= n_crc_lo;
        end
    end

    assign o_hdr           = r_hdr;
    assign o_flags.esc     = r_esc;
    assign o_flags.discard = r_discard;
    assign o_wr_addr       = r_count[ADDR_W-1:0];
    assign o_wr_data       = i_ctl.fbyte;

endmodule

// ----- hdl/serial_frame_deframer_crc16.sv -----
// Serial frame deframer with CRC-16/XMODEM check, top level.
// The input is taken only in SQ_IDLE; each byte then passes SQ_FEED1, SQ_CLEAR and SQ_FEED2
// before the next is taken. A single result adds SQ_ONE, a payload run adds SQ_RUN_RD (one
// read of the payload store) and SQ_RUN_WR (the load of the output register) per payload
// byte, and a stalled output holds SQ_ONE and SQ_RUN_WR.
// Reset (i_rst_n low, synchronous) clears parser, escape, discard and config to defaults.
module serial_frame_deframer_crc16 #(
    parameter int MAX_PAYLOAD = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  sfd_pkg::t_in_item              i_in_item,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output sfd_pkg::t_out_item             o_out_item,
    input  logic                           i_cfg_we,
    input  logic [sfd_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [sfd_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    localparam int CAP    = (MAX_PAYLOAD < sfd_pkg::STORE_DEPTH) ? MAX_PAYLOAD
                                                                 : sfd_pkg::STORE_DEPTH;
    localparam int ADDR_W = (CAP > 1) ? $clog2(CAP) : 1;

    // configuration
    logic       r_check_crc;
    logic [7:0] r_string_type;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_check_crc   <= 1'b1;
            r_string_type <= 8'h00;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                sfd_pkg::CFG_CHECK_CRC:   r_check_crc   <= i_cfg_data[0];
                sfd_pkg::CFG_STRING_TYPE: r_string_type <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // parser and payload store
    sfd_pkg::t_feed_ctl    ctl;
    sfd_pkg::t_feed_rsp    rsp;
    sfd_pkg::t_hdr         hdr;
    sfd_pkg::t_parse_flags flags;
    logic                  wr_en;
    logic [ADDR_W-1:0]     wr_addr;
    logic [7:0]            wr_data;
    logic                  rd_en;
    logic [7:0]            rd_data;

    sfd_parser #(
        .CAPACITY (CAP),
        .ADDR_W   (ADDR_W)
    ) u_parser (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (ctl),
        .i_check_crc   (r_check_crc),
        .i_string_type (r_string_type),
        .o_hdr         (hdr),
        .o_rsp         (rsp),
        .o_flags       (flags),
        .o_wr_en       (wr_en),
        .o_wr_addr     (wr_addr),
        .o_wr_data     (wr_data)
    );

    // sequencer registers
    sfd_pkg::t_seq     r_state, n_state;
    logic [7:0]        r_byte;
    logic              r_start;
    logic              r_do_f1;
    logic              r_skip2;
    logic              r_second;
    logic [2:0]        r_status;
    logic [ADDR_W-1:0] r_k;

    sfd_payload_ram #(
        .DEPTH  (CAP),
        .ADDR_W (ADDR_W)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_addr),
        .i_wdata (wr_data),
        .i_re    (rd_en),
        .i_raddr (r_k),
        .o_rdata (rd_data)
    );

    // output register
    sfd_pkg::t_out_item r_out, n_out;
    logic               r_out_valid;
    logic               out_free;
    logic               load_one;
    logic               load_run;
    logic               run_last;
    logic               in_acc;
    sfd_pkg::t_seq      resume;

    assign out_free = !r_out_valid || !i_out_stall;
    assign run_last = ((8'(r_k) + 8'd1) == hdr.length);
    assign in_acc   = i_in_valid && !o_in_stall;
    assign resume   = r_second ? sfd_pkg::SQ_IDLE : sfd_pkg::SQ_CLEAR;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            sfd_pkg::SQ_IDLE: begin
                if (in_acc) n_state = sfd_pkg::SQ_FEED1;
            end
            sfd_pkg::SQ_FEED1, sfd_pkg::SQ_FEED2: begin
                case (rsp.kind)
                    sfd_pkg::RQ_SINGLE: n_state = sfd_pkg::SQ_ONE;
                    sfd_pkg::RQ_RUN:    n_state = sfd_pkg::SQ_RUN_RD;
                    default: begin
                        n_state = (r_state == sfd_pkg::SQ_FEED1) ? sfd_pkg::SQ_CLEAR
                                                                  : sfd_pkg::SQ_IDLE;
                    end
                endcase
            end
            sfd_pkg::SQ_CLEAR: n_state = sfd_pkg::SQ_FEED2;
            sfd_pkg::SQ_ONE: begin
                if (out_free) n_state = resume;
            end
            sfd_pkg::SQ_RUN_RD: n_state = sfd_pkg::SQ_RUN_WR;
            sfd_pkg::SQ_RUN_WR: begin
                if (out_free) n_state = run_last ? resume : sfd_pkg::SQ_RUN_RD;
            end
            default: n_state = sfd_pkg::SQ_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        ctl        = '0;
        ctl.fbyte  = r_byte;
        rd_en      = 1'b0;
        load_one   = 1'b0;
        load_run   = 1'b0;
        o_in_stall = 1'b1;
        case (r_state)
            sfd_pkg::SQ_IDLE: o_in_stall = 1'b0;
            sfd_pkg::SQ_FEED1: begin
                // pending escape: 7D 5E -> 7E, otherwise a plain 7D
                ctl.feed    = r_do_f1;
                ctl.fbyte   = (!r_start && (r_byte == sfd_pkg::ESC_FLAG)) ? sfd_pkg::FLAG_BYTE
                                                                          : sfd_pkg::ESC_BYTE;
                ctl.esc_clr = 1'b1;
            end
            sfd_pkg::SQ_CLEAR: ctl.clear = r_start;
            sfd_pkg::SQ_FEED2: begin
                if (!r_skip2) begin
                    if (r_byte == sfd_pkg::ESC_BYTE) ctl.esc_set = !flags.discard;
                    else                             ctl.feed    = 1'b1;
                end
            end
            sfd_pkg::SQ_ONE:    load_one = out_free;
            sfd_pkg::SQ_RUN_RD: rd_en    = 1'b1;
            sfd_pkg::SQ_RUN_WR: load_run = out_free;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sfd_pkg::SQ_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_byte  <= i_in_item.raw_byte;
            r_start <= i_in_item.buffer_start;
            r_do_f1 <= flags.esc;
            r_skip2 <= !i_in_item.buffer_start && flags.esc &&
                       ((i_in_item.raw_byte == sfd_pkg::ESC_FLAG) ||
                        (i_in_item.raw_byte == sfd_pkg::ESC_ESC));
        end
        if ((r_state == sfd_pkg::SQ_FEED1) || (r_state == sfd_pkg::SQ_FEED2)) begin
            r_second <= (r_state == sfd_pkg::SQ_FEED2);
            r_status <= rsp.status;
            r_k      <= '0;
        end
        if (load_run && !run_last) begin
            r_k <= r_k + ADDR_W'(1);
        end
    end

    always_comb begin
        n_out.dest_address   = hdr.dest;
        n_out.message_type   = hdr.msg_code;
        n_out.group_id       = hdr.group;
        n_out.payload_length = hdr.length;
        if (load_run) begin
            n_out.payload_byte = rd_data;
            n_out.byte_index   = sfd_pkg::IDX_W'(r_k);
            n_out.has_payload  = 1'b1;
            n_out.status       = sfd_pkg::ST_OK;
            n_out.last         = run_last;
        end else begin
            n_out.payload_byte = 8'h00;
            n_out.byte_index   = '0;
            n_out.has_payload  = 1'b0;
            n_out.status       = r_status;
            n_out.last         = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_one || load_run) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_one || load_run) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

`ifndef SYNTHESIS
    a_idx_in_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.has_payload) |->
        ({3'b000, r_out.byte_index} < r_out.payload_length))
        else $error("payload index beyond frame length");

    a_esc_discard: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(flags.esc && flags.discard))
        else $error("escape pending while discarding");

    a_run_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sfd_pkg::SQ_RUN_RD) |-> (hdr.length != 8'h00))
        else $error("payload run started with zero length");

    a_run_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_run |-> $past(rd_en) || $past(r_state == sfd_pkg::SQ_RUN_WR))
        else $error("run result loaded without a store read");
`endif

endmodule

// ----- tb/serial_frame_deframer_crc16_tb.sv -----
// Self-checking testbench for serial_frame_deframer_crc16: escaped byte frames in, header and
// payload runs out, each result checked against a built-in deframer/CRC-16 predictor.
// Depends on sfd_pkg (payload structs, codes) and the top-level RTL only.
`timescale 1ns / 100ps

module serial_frame_deframer_crc16_tb;

    localparam int FRAME_CAP    = 32;   // MAX_PAYLOAD clipped to the store depth
    localparam int DRAIN_CYCLES = 40;
    localparam int PHASE_ITEMS  = 50;

    logic                           i_clk      = 1'b0;
    logic                           i_rst_n    = 1'b0;
    logic                           i_in_valid = 1'b0;
    logic                           o_in_stall;
    sfd_pkg::t_in_item              i_in_item  = '0;
    logic                           o_out_valid;
    logic                           i_out_stall = 1'b0;
    sfd_pkg::t_out_item             o_out_item;
    logic                           i_cfg_we   = 1'b0;
    logic [sfd_pkg::CFG_IDX_W-1:0]  i_cfg_idx  = '0;
    logic [sfd_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;

    serial_frame_deframer_crc16 u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    // predictor state
    bit              cfg_check;
    logic [7:0]      cfg_str;
    sfd_pkg::t_phase rx_phase;
    bit              rx_esc;
    bit              rx_discard;
    logic [15:0]     hdr_dest;
    logic [7:0]      hdr_type;
    logic [7:0]      hdr_group;
    logic [7:0]      hdr_len;
    logic [7:0]      body_cnt;
    logic [7:0]      body_store [FRAME_CAP];
    logic [15:0]     crc_acc;
    logic [7:0]      crc_lo_rx;

    sfd_pkg::t_in_item  tx_pending [$];
    sfd_pkg::t_out_item exp_results [$];
    sfd_pkg::t_out_item want_item;
    logic [7:0] frame_body [$];

    int idle_pct     = 0;
    int stall_pct    = 0;
    int raw_esc_pct  = 0;
    int mismatches   = 0;
    int items_sent   = 0;
    int results_seen = 0;
    bit in_taken     = 1'b0;
    bit need_start   = 1'b0;

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    function automatic logic [15:0] crc_next(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] r;
        r = crc;
        for (int i = 7; i >= 0; i--) begin
            r = {r[14:0], 1'b0} ^ ((r[15] ^ b[i]) ? sfd_pkg::CRC_POLY : 16'h0000);
        end
        return r;
    endfunction

    task automatic clear_parser();
        rx_phase   = sfd_pkg::PH_TYPE;
        rx_esc     = 1'b0;
        rx_discard = 1'b0;
        hdr_dest   = '0;
        hdr_type   = '0;
        hdr_group  = '0;
        hdr_len    = '0;
        body_cnt   = '0;
        crc_acc    = '0;
        crc_lo_rx  = '0;
    endtask

    task automatic emit(input logic [7:0] pb, input logic [4:0] idx, input logic has,
                        input sfd_pkg::t_status st, input logic lst);
        sfd_pkg::t_out_item r;
        r.dest_address   = hdr_dest;
        r.message_type   = hdr_type;
        r.group_id       = hdr_group;
        r.payload_length = hdr_len;
        r.payload_byte   = pb;
        r.byte_index     = idx;
        r.has_payload    = has;
        r.status         = st;
        r.last           = lst;
        exp_results.push_back(r);
    endtask

    // one unescaped byte through the frame parser
    task automatic parse_byte(input logic [7:0] b);
        logic [15:0] rx_crc;
        if (!rx_discard) begin
            case (rx_phase)
                sfd_pkg::PH_TYPE: begin
                    hdr_dest  = '0;
                    hdr_group = '0;
                    hdr_len   = '0;
                    hdr_type  = b;
                    body_cnt  = '0;
                    crc_lo_rx = '0;
                    crc_acc   = crc_next(16'h0000, b);
                    rx_phase  = sfd_pkg::PH_DEST_LO;
                end
                sfd_pkg::PH_DEST_LO: begin
                    // type byte is judged only once the next byte shows up
                    if (hdr_type != sfd_pkg::PKT_TYPE) begin
                        hdr_type = '0;
                        emit(8'h00, 5'd0, 1'b0, sfd_pkg::ST_BAD_TYPE, 1'b1);
                        rx_discard = 1'b1;
                        rx_phase   = sfd_pkg::PH_TYPE;
                    end else begin
                        hdr_dest = {8'h00, b};
                        crc_acc  = crc_next(crc_acc, b);
                        rx_phase = sfd_pkg::PH_DEST_HI;
                    end
                end
                sfd_pkg::PH_DEST_HI: begin
                    hdr_dest[15:8] = b;
                    crc_acc  = crc_next(crc_acc, b);
                    rx_phase = sfd_pkg::PH_MSG;
                end
                sfd_pkg::PH_MSG: begin
                    hdr_type = b;
                    crc_acc  = crc_next(crc_acc, b);
                    rx_phase = sfd_pkg::PH_GROUP;
                end
                sfd_pkg::PH_GROUP: begin
                    hdr_group = b;
                    crc_acc   = crc_next(crc_acc, b);
                    rx_phase  = sfd_pkg::PH_LEN;
                end
                sfd_pkg::PH_LEN: begin
                    hdr_len = b;
                    if (b > FRAME_CAP) begin
                        emit(8'h00, 5'd0, 1'b0, sfd_pkg::ST_TOO_LONG, 1'b1);
                        rx_discard = 1'b1;
                        rx_phase   = sfd_pkg::PH_TYPE;
                    end else begin
                        crc_acc  = crc_next(crc_acc, b);
                        body_cnt = '0;
                        rx_phase = sfd_pkg::PH_BODY;
                    end
                end
                default: begin
                    if (body_cnt < hdr_len) begin
                        body_store[body_cnt[4:0]] = b;
                        crc_acc  = crc_next(crc_acc, b);
                        body_cnt = body_cnt + 8'd1;
                    end else if (body_cnt == hdr_len) begin
                        crc_lo_rx = b;
                        body_cnt  = body_cnt + 8'd1;
                    end else begin
                        rx_crc   = {b, crc_lo_rx};
                        rx_phase = sfd_pkg::PH_TYPE;
                        if (cfg_check && rx_crc != crc_acc) begin
                            emit(8'h00, 5'd0, 1'b0, sfd_pkg::ST_CRC, 1'b1);
                            rx_discard = 1'b1;
                        end else if (hdr_type != cfg_str) begin
                            emit(8'h00, 5'd0, 1'b0, sfd_pkg::ST_NOT_STRING, 1'b1);
                        end else if (hdr_len == 8'd0) begin
                            emit(8'h00, 5'd0, 1'b0, sfd_pkg::ST_OK, 1'b1);
                        end else begin
                            for (int k = 0; k < hdr_len; k++) begin
                                emit(body_store[k], 5'(k), 1'b1, sfd_pkg::ST_OK,
                                     1'(k + 1 == int'(hdr_len)));
                            end
                        end
                    end
                end
            endcase
        end
    endtask

    // one raw transaction: escape decoding, then the parser
    task automatic deframe_step(input sfd_pkg::t_in_item it);
        logic [7:0] b;
        b = it.raw_byte;
        if (it.buffer_start) begin
            // a dangling escape belongs to the old buffer as a plain byte
            if (rx_esc)
                parse_byte(sfd_pkg::ESC_BYTE);
            clear_parser();
        end
        if (!rx_discard) begin
            if (rx_esc) begin
                rx_esc = 1'b0;
                if (b == sfd_pkg::ESC_FLAG) begin
                    parse_byte(sfd_pkg::FLAG_BYTE);
                end else if (b == sfd_pkg::ESC_ESC) begin
                    parse_byte(sfd_pkg::ESC_BYTE);
                end else begin
                    parse_byte(sfd_pkg::ESC_BYTE);
                    if (!rx_discard) begin
                        if (b == sfd_pkg::ESC_BYTE)
                            rx_esc = 1'b1;
                        else
                            parse_byte(b);
                    end
                end
            end else if (b == sfd_pkg::ESC_BYTE) begin
                rx_esc = 1'b1;
            end else begin
                parse_byte(b);
            end
        end
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endtask

    // input acceptance feeds the predictor; output acceptance is checked
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_taken <= 1'b0;
        end else begin
            in_taken <= i_in_valid && !o_in_stall;
            if (i_in_valid && !o_in_stall) begin
                deframe_step(i_in_item);
                items_sent++;
            end
            if (o_out_valid && !i_out_stall) begin
                results_seen++;
                if (exp_results.size() == 0) begin
                    $error("result transaction with nothing expected: %p", o_out_item);
                    mismatches++;
                end else begin
                    want_item = exp_results.pop_front();
                    check_field("dest_address", want_item.dest_address,
                                o_out_item.dest_address);
                    check_field("message_type", 16'(want_item.message_type),
                                16'(o_out_item.message_type));
                    check_field("group_id", 16'(want_item.group_id),
                                16'(o_out_item.group_id));
                    check_field("payload_length", 16'(want_item.payload_length),
                                16'(o_out_item.payload_length));
                    check_field("payload_byte", 16'(want_item.payload_byte),
                                16'(o_out_item.payload_byte));
                    check_field("byte_index", 16'(want_item.byte_index),
                                16'(o_out_item.byte_index));
                    check_field("has_payload", 16'(want_item.has_payload),
                                16'(o_out_item.has_payload));
                    check_field("status", 16'(want_item.status), 16'(o_out_item.status));
                    check_field("last", 16'(want_item.last), 16'(o_out_item.last));
                end
            end
        end
    end

    // driver: inputs move on the falling edge
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid  <= 1'b0;
            i_out_stall <= 1'b0;
        end else begin
            if (!i_in_valid || in_taken) begin
                if (tx_pending.size() != 0 && $urandom_range(99) >= idle_pct) begin
                    i_in_item  <= tx_pending.pop_front();
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
            i_out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    task automatic write_reg(input sfd_pkg::t_cfg_idx idx, input logic [7:0] val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        if (idx == sfd_pkg::CFG_CHECK_CRC)
            cfg_check = val[0];
        else
            cfg_str = val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // sender holds off until every result is in and the block has gone quiet
    task automatic wait_idle();
        while (tx_pending.size() != 0 || i_in_valid)
            @(posedge i_clk);
        while (exp_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic push_raw(input logic [7:0] b, input bit st);
        sfd_pkg::t_in_item it;
        it.raw_byte     = b;
        it.buffer_start = st;
        tx_pending.push_back(it);
    endtask

    task automatic fill_body(input int n);
        logic [31:0] specials;
        specials = {sfd_pkg::ESC_BYTE, sfd_pkg::FLAG_BYTE, sfd_pkg::ESC_FLAG, sfd_pkg::ESC_ESC};
        frame_body.delete();
        repeat (n) begin
            if ($urandom_range(3) == 0)
                frame_body.push_back(specials[8 * $urandom_range(3) +: 8]);
            else
                frame_body.push_back(8'($urandom));
        end
    endtask

    // header + frame_body + CRC, escaped; tail_esc ends on a lone raw 0x7D instead of CRC high
    task automatic queue_frame(input bit start, input logic [7:0] lead, input logic [15:0] dest,
                               input logic [7:0] mtype, input logic [7:0] grp,
                               input logic [7:0] len, input logic [15:0] crc_xor,
                               input bit tail_esc);
        logic [7:0]  u [$];
        logic [15:0] crc;
        bit          st;
        u.push_back(lead);
        u.push_back(dest[7:0]);
        u.push_back(dest[15:8]);
        u.push_back(mtype);
        u.push_back(grp);
        u.push_back(len);
        foreach (frame_body[i]) u.push_back(frame_body[i]);
        crc = 16'h0000;
        foreach (u[i]) crc = crc_next(crc, u[i]);
        crc = crc ^ crc_xor;
        u.push_back(crc[7:0]);
        if (!tail_esc)
            u.push_back(crc[15:8]);
        st = start;
        for (int i = 0; i < u.size(); i++) begin
            if (u[i] == sfd_pkg::FLAG_BYTE) begin
                push_raw(sfd_pkg::ESC_BYTE, st);
                push_raw(sfd_pkg::ESC_FLAG, 1'b0);
            end else if (u[i] == sfd_pkg::ESC_BYTE &&
                         !(i + 1 < u.size() && u[i+1] != sfd_pkg::ESC_FLAG &&
                           u[i+1] != sfd_pkg::ESC_ESC &&
                           $urandom_range(99) < raw_esc_pct)) begin
                push_raw(sfd_pkg::ESC_BYTE, st);
                push_raw(sfd_pkg::ESC_ESC, 1'b0);
            end else begin
                push_raw(u[i], st);
            end
            st = 1'b0;
        end
        if (tail_esc)
            push_raw(sfd_pkg::ESC_BYTE, 1'b0);
    endtask

    // mostly well-formed frames, some broken ones and raw noise
    task automatic queue_random_chunk();
        int          kind;
        bit          st;
        logic [7:0]  len;
        logic [7:0]  lead;
        logic [7:0]  mtype;
        logic [15:0] cx;
        kind = $urandom_range(99);
        st = need_start || ($urandom_range(99) < 25);
        need_start = 1'b0;
        raw_esc_pct = 50;
        if (kind < 8) begin
            push_raw(8'($urandom), st);
            repeat ($urandom_range(5)) push_raw(8'($urandom), $urandom_range(99) < 20);
            need_start = 1'b1;
        end else begin
            if ($urandom_range(9) == 0)
                len = 8'($urandom_range(FRAME_CAP, 7));
            else
                len = 8'($urandom_range(6));
            lead  = sfd_pkg::PKT_TYPE;
            cx    = 16'h0000;
            mtype = ($urandom_range(99) < 60) ? cfg_str : 8'($urandom);
            if (kind < 16) begin
                lead = 8'($urandom);
                if (lead == sfd_pkg::PKT_TYPE)
                    lead = ~lead;
                need_start = 1'b1;
            end else if (kind < 24) begin
                cx = 16'($urandom_range(16'hFFFF, 1));
                need_start = cfg_check;
            end else if (kind < 29) begin
                len = 8'($urandom_range(255, FRAME_CAP + 1));
                need_start = 1'b1;
            end
            fill_body((len > FRAME_CAP) ? 3 : int'(len));
            queue_frame(st, lead, 16'($urandom), mtype, 8'($urandom), len, cx,
                        $urandom_range(99) < 4);
        end
    endtask

    initial begin
        int phase_items;
        int n0;
        clear_parser();
        cfg_check = 1'b1;
        cfg_str   = 8'h00;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        write_reg(sfd_pkg::CFG_CHECK_CRC, 8'h01);
        write_reg(sfd_pkg::CFG_STRING_TYPE, 8'h00);
        idle_pct  = 33;
        stall_pct = 33;

        // directed: empty payload, escapes, other type, bad type, CRC, oversize
        raw_esc_pct = 0;
        frame_body.delete();
        queue_frame(1'b1, sfd_pkg::PKT_TYPE, 16'h0000, 8'h00, 8'h00, 8'd0, 16'h0000, 1'b0);
        frame_body.delete();
        frame_body.push_back(sfd_pkg::FLAG_BYTE);
        frame_body.push_back(sfd_pkg::ESC_BYTE);
        queue_frame(1'b0, sfd_pkg::PKT_TYPE, 16'h7E7D, 8'h00, sfd_pkg::FLAG_BYTE, 8'd2,
                    16'h0000, 1'b0);
        fill_body(1);
        queue_frame(1'b0, sfd_pkg::PKT_TYPE, 16'h1234, 8'h5A, 8'h01, 8'd1, 16'h0000, 1'b0);
        fill_body(2);
        queue_frame(1'b0, 8'h41, 16'hABCD, 8'h00, 8'h02, 8'd2, 16'h0000, 1'b0);
        fill_body(2);
        queue_frame(1'b1, sfd_pkg::PKT_TYPE, 16'h0102, 8'h00, 8'h03, 8'd2, 16'h0001, 1'b0);
        frame_body.delete();
        queue_frame(1'b1, sfd_pkg::PKT_TYPE, 16'h8001, 8'h00, 8'h04, 8'(FRAME_CAP + 1),
                    16'h0000, 1'b0);
        queue_frame(1'b1, sfd_pkg::PKT_TYPE, 16'h8002, 8'h00, 8'h05, 8'hFF, 16'h0000, 1'b0);
        // lone type byte at buffer end, then an unfinished frame left with an escape open
        push_raw(sfd_pkg::PKT_TYPE, 1'b1);
        push_raw(sfd_pkg::PKT_TYPE, 1'b1);
        push_raw(8'h10, 1'b0);
        push_raw(sfd_pkg::ESC_BYTE, 1'b0);
        frame_body.delete();
        repeat (FRAME_CAP) frame_body.push_back(8'hFF);
        queue_frame(1'b1, sfd_pkg::PKT_TYPE, 16'hFFFF, 8'h00, 8'hFF, 8'(FRAME_CAP),
                    16'h0000, 1'b0);
        // 0x7D before an ordinary byte stays literal
        raw_esc_pct = 100;
        frame_body.delete();
        frame_body.push_back(sfd_pkg::ESC_BYTE);
        frame_body.push_back(8'h11);
        frame_body.push_back(sfd_pkg::ESC_BYTE);
        frame_body.push_back(sfd_pkg::FLAG_BYTE);
        queue_frame(1'b0, sfd_pkg::PKT_TYPE, 16'h5D5E, 8'h00, 8'h06, 8'd4, 16'h0000, 1'b0);
        raw_esc_pct = 0;
        wait_idle();

        write_reg(sfd_pkg::CFG_CHECK_CRC, 8'h00);
        write_reg(sfd_pkg::CFG_STRING_TYPE, 8'hFF);
        fill_body(3);
        queue_frame(1'b1, sfd_pkg::PKT_TYPE, 16'h4242, 8'hFF, 8'h07, 8'd3, 16'hBEEF, 1'b0);
        // CRC high byte is an escape still open when the next buffer starts
        fill_body(1);
        queue_frame(1'b0, sfd_pkg::PKT_TYPE, 16'h0000, 8'hFF, 8'h08, 8'd1, 16'h0000, 1'b1);
        frame_body.delete();
        queue_frame(1'b1, sfd_pkg::PKT_TYPE, 16'h0001, 8'hFF, 8'h09, 8'd0, 16'h0000, 1'b0);
        wait_idle();

        for (int p = 0; p < 4; p++) begin
            case (p)
                0: begin
                    write_reg(sfd_pkg::CFG_CHECK_CRC, 8'h01);
                    write_reg(sfd_pkg::CFG_STRING_TYPE, 8'($urandom));
                end
                1: begin
                    write_reg(sfd_pkg::CFG_CHECK_CRC, 8'h00);
                    write_reg(sfd_pkg::CFG_STRING_TYPE, 8'h00);
                end
                2: begin
                    write_reg(sfd_pkg::CFG_CHECK_CRC, 8'h01);
                    write_reg(sfd_pkg::CFG_STRING_TYPE, 8'hFF);
                end
                default: begin
                    write_reg(sfd_pkg::CFG_CHECK_CRC, 8'($urandom_range(1)));
                    write_reg(sfd_pkg::CFG_STRING_TYPE, 8'($urandom));
                end
            endcase
            // one phase runs with no idling on either side
            idle_pct  = (p == 1) ? 0 : 33;
            stall_pct = (p == 1) ? 0 : 33;
            need_start  = 1'b1;
            phase_items = 0;
            while (phase_items < PHASE_ITEMS || (p == 3 && results_seen < 60)) begin
                if (tx_pending.size() > 16) begin
                    @(posedge i_clk);
                end else begin
                    n0 = tx_pending.size();
                    queue_random_chunk();
                    phase_items += tx_pending.size() - n0;
                end
            end
            wait_idle();
        end

        if (exp_results.size() != 0) begin
            $error("%0d expected results never arrived", exp_results.size());
            mismatches++;
        end
        $display("Covered %0d input and %0d result transactions over six register settings,",
                 items_sent, results_seen);
        $display("with escapes, all error kinds, buffer restarts and random stalls.");
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial begin
        #2_000_000;
        $error("run did not complete in time");
        $display("== FAIL ==");
        $finish;
    end

endmodule
